@@ hdl/rbs_pkg.sv @@
// Shared types and constants for the reconnect backoff scheduler.
package rbs_pkg;

    localparam int DLY_BITS    = 31;
    localparam int FACTOR_BITS = 8;
    localparam int PROD_BITS   = DLY_BITS + FACTOR_BITS;
    localparam int ACT_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DLY_BITS-1:0]    INITIAL_RST = DLY_BITS'(100);
    localparam logic [DLY_BITS-1:0]    MAX_RST     = DLY_BITS'(5000);
    localparam logic [FACTOR_BITS-1:0] FACTOR_RST  = FACTOR_BITS'(2);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_INITIAL = 2'd0,
        REG_MAX     = 2'd1,
        REG_FACTOR  = 2'd2
    } t_reg_idx;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_ATTACH  = 2'd0,
        ACT_LOST    = 2'd1,
        ACT_ATTEMPT = 2'd2,
        ACT_CHECK   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_DUE
    } t_state;

    typedef struct packed {
        logic [DLY_BITS-1:0]    initial_dly;
        logic [DLY_BITS-1:0]    max_dly;
        logic [FACTOR_BITS-1:0] factor;
    } t_cfg;

endpackage

@@ hdl/rbs_ifs.sv @@
// Handshake interfaces for event, result and configuration channels.
interface rbs_evt_if #(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic                 succeeded;
    logic [TIME_BITS-1:0] now_ms;

    modport source (output valid, action, succeeded, now_ms, input ready);
    modport sink   (input valid, action, succeeded, now_ms, output ready);
endinterface

interface rbs_res_if #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic                  link_up;
    logic                  retry_due;
    logic [COUNT_BITS-1:0] retry_count;
    logic [TIME_BITS:0]    next_retry_ms;

    modport source (output valid, link_up, retry_due, retry_count, next_retry_ms,
                    input ready);
    modport sink   (input valid, link_up, retry_due, retry_count, next_retry_ms,
                    output ready);
endinterface

interface rbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/rbs_cfg_regs.sv @@
// Configuration register bank for the backoff scheduler.
module rbs_cfg_regs
    import rbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbs_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_dly <= INITIAL_RST;
            r_cfg.max_dly     <= MAX_RST;
            r_cfg.factor      <= FACTOR_RST;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_INITIAL: r_cfg.initial_dly <= i_cfg.data;
                REG_MAX:     r_cfg.max_dly     <= i_cfg.data;
                REG_FACTOR:  r_cfg.factor      <= i_cfg.data[FACTOR_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/rbs_backoff.sv @@
// Iterative backoff delay unit: one shared multiply and cap compare per cycle.
module rbs_backoff
    import rbs_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_count,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DLY_BITS-1:0]   o_delay
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DLY_BITS-1:0]   r_d, n_d;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic [PROD_BITS-1:0]  w_prod;
    logic [DLY_BITS-1:0]   w_lo;

    assign w_lo   = (i_cfg.initial_dly < i_cfg.max_dly) ? i_cfg.initial_dly : i_cfg.max_dly;
    assign w_prod = PROD_BITS'(r_d) * PROD_BITS'(i_cfg.factor);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_d    = r_d;
        n_left = r_left;
        if (r_busy) begin
            // stop at the cap, or after the last step
            if (w_prod >= PROD_BITS'(i_cfg.max_dly)) begin
                n_d    = i_cfg.max_dly;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_d    = w_prod[DLY_BITS-1:0];
                n_left = r_left - 1'b1;
                if (r_left == COUNT_BITS'(1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end else if (i_start) begin
            if (i_count == '0 || i_cfg.factor <= FACTOR_BITS'(1)) begin
                n_d    = w_lo;
                n_done = 1'b1;
            end else if (i_cfg.initial_dly == '0) begin
                n_d    = '0;
                n_done = 1'b1;
            end else begin
                n_d    = i_cfg.initial_dly;
                n_left = i_count;
                n_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_left <= n_left;
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_delay = r_d;

endmodule

@@ hdl/reconnect_backoff_scheduler_core.sv @@
// Reconnect backoff scheduler top level: event sequencer, link state and result register.
// Each event yields one result showing the link state after the event. Attach, check and
// successful or ignored attempts pass from the execute state straight to the result state
// (S_EXEC, S_DUE). A loss or a failed attempt also waits in S_WAIT for the delay unit,
// which skips the multiply when the delay needs none (zero count, growth factor of 1 or
// less, or zero initial delay) and otherwise steps the shared 31x8 multiply-and-cap loop
// until the cap or the retry count is reached. A new event is accepted only while the
// sequencer is idle, which it re-enters as the previous result is loaded; a result still
// waiting in the output register holds the next event's result, and with it the
// sequencer, until it is taken.
module reconnect_backoff_scheduler_core
    import rbs_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbs_cfg_if.sink     i_cfg,
    rbs_evt_if.sink     i_evt,
    rbs_res_if.source   o_res
);

    t_cfg                  w_cfg;
    t_state                r_state, n_state;

    t_action               r_action;
    logic                  r_ok;
    logic [TIME_BITS-1:0]  r_now;

    logic                  r_link_up, n_link_up;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TIME_BITS:0]    r_retry, n_retry;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_link, r_out_due;
    logic [COUNT_BITS-1:0] r_out_count;
    logic [TIME_BITS:0]    r_out_retry;
    logic                  w_load_out;
    logic                  w_due;

    logic                  w_bo_start;
    logic [COUNT_BITS-1:0] w_bo_count;
    logic                  w_bo_busy, w_bo_done;
    logic [DLY_BITS-1:0]   w_bo_delay;
    logic                  w_evt_acc;

    rbs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    rbs_backoff #(
        .COUNT_BITS (COUNT_BITS)
    ) u_backoff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_start (w_bo_start),
        .i_count (w_bo_count),
        .o_busy  (w_bo_busy),
        .o_done  (w_bo_done),
        .o_delay (w_bo_delay)
    );

    assign i_evt.ready = (r_state == S_IDLE);
    assign w_evt_acc   = i_evt.valid && i_evt.ready;
    assign w_due       = !r_link_up && ({1'b0, r_now} >= r_retry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_link_up   <= 1'b1;
            r_count     <= '0;
            r_retry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_link_up   <= n_link_up;
            r_count     <= n_count;
            r_retry     <= n_retry;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt_acc) begin
            r_action <= t_action'(i_evt.action);
            r_ok     <= i_evt.succeeded;
            r_now    <= i_evt.now_ms;
        end
        if (w_load_out) begin
            r_out_link  <= r_link_up;
            r_out_due   <= w_due;
            r_out_count <= r_count;
            r_out_retry <= r_retry;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_link_up   = r_link_up;
        n_count     = r_count;
        n_retry     = r_retry;
        w_bo_start  = 1'b0;
        w_bo_count  = '0;
        w_load_out  = 1'b0;
        n_out_valid = r_out_valid && !o_res.ready;

        case (r_state)
            S_IDLE: begin
                if (w_evt_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DUE;
                case (r_action)
                    ACT_ATTACH: begin
                        n_link_up = 1'b1;
                        n_count   = '0;
                        n_retry   = '0;
                    end
                    ACT_LOST: begin
                        n_link_up  = 1'b0;
                        n_count    = '0;
                        w_bo_start = 1'b1;
                        n_state    = S_WAIT;
                    end
                    ACT_ATTEMPT: begin
                        if (r_ok) begin
                            n_link_up = 1'b1;
                            n_count   = '0;
                            n_retry   = '0;
                        end else if (!r_link_up) begin
                            // saturate the count; delay follows the saturated value
                            if (r_count != '1) begin
                                n_count = r_count + 1'b1;
                            end
                            w_bo_count = n_count;
                            w_bo_start = 1'b1;
                            n_state    = S_WAIT;
                        end
                    end
                    ACT_CHECK: ;
                    default: ;
                endcase
            end
            S_WAIT: begin
                if (w_bo_done) begin
                    n_retry = {1'b0, r_now} + (TIME_BITS+1)'(w_bo_delay);
                    n_state = S_DUE;
                end
            end
            S_DUE: begin
                // hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.link_up       = r_out_link;
    assign o_res.retry_due     = r_out_due;
    assign o_res.retry_count   = r_out_count;
    assign o_res.next_retry_ms = r_out_retry;

`ifndef NO_ASSERTIONS
    a_up_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link_up |-> (r_count == '0 && r_retry == '0))
        else $error("link up with a pending retry schedule");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bo_busy |-> (r_state == S_WAIT && !i_evt.ready))
        else $error("backoff loop running outside the wait state");

    a_delay_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bo_done |-> (w_bo_delay <= w_cfg.max_dly))
        else $error("backoff delay above the cap");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not return to idle");
`endif

endmodule

@@ tb/rbs_backoff_tracker.sv @@
// Link-state tracker: predicts every scheduler result and compares it with the block's output.
module rbs_backoff_tracker
    import rbs_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rbs_cfg_if   i_cfg,
    rbs_evt_if   i_evt,
    rbs_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_due_seen,
    output int   o_peak_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                  link_up;
        logic                  retry_due;
        logic [COUNT_BITS-1:0] retry_count;
        logic [TIME_BITS:0]    next_retry_ms;
    } sched_result_t;

    localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

    logic [DLY_BITS-1:0]    init_ms;
    logic [DLY_BITS-1:0]    cap_ms;
    logic [FACTOR_BITS-1:0] factor;

    logic                  link_up_q;
    logic [COUNT_BITS-1:0] fails_q;
    logic [TIME_BITS:0]    retry_at_q;

    sched_result_t expected_q[$];
    int            fails;
    int            checked;
    int            due_seen;
    int            peak;

    function automatic logic [63:0] backoff_ms(input logic [COUNT_BITS-1:0] count);
        logic [63:0] d;
        logic [63:0] floor_ms;
        d        = 64'(init_ms);
        floor_ms = (init_ms < cap_ms) ? 64'(init_ms) : 64'(cap_ms);
        if (count == '0 || factor <= FACTOR_BITS'(1)) return floor_ms;
        if (d == 64'd0) return 64'd0;
        // multiply once per failed attempt, stop as soon as the cap is reached
        for (int i = 0; i < int'(count); i++) begin
            d = d * 64'(factor);
            if (d >= 64'(cap_ms)) return 64'(cap_ms);
        end
        return d;
    endfunction

    function automatic sched_result_t advance_link(input t_action act, input logic ok,
                                                   input logic [TIME_BITS-1:0] now);
        sched_result_t r;
        if (act == ACT_ATTACH || (act == ACT_ATTEMPT && ok)) begin
            link_up_q  = 1'b1;
            fails_q    = '0;
            retry_at_q = '0;
        end else if (act == ACT_LOST) begin
            link_up_q  = 1'b0;
            fails_q    = '0;
            retry_at_q = {1'b0, now} + (TIME_BITS+1)'(backoff_ms('0));
        end else if (act == ACT_ATTEMPT && !link_up_q) begin
            // saturate the count; the delay then stays where it is
            if (fails_q != COUNT_SAT) fails_q = fails_q + 1'b1;
            retry_at_q = {1'b0, now} + (TIME_BITS+1)'(backoff_ms(fails_q));
        end
        r.link_up       = link_up_q;
        r.retry_due     = !link_up_q && ({1'b0, now} >= retry_at_q);
        r.retry_count   = fails_q;
        r.next_retry_ms = retry_at_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        sched_result_t got;
        sched_result_t want;
        sched_result_t pred;
        if (!i_rst_n) begin
            init_ms    = INITIAL_RST;
            cap_ms     = MAX_RST;
            factor     = FACTOR_RST;
            link_up_q  = 1'b1;
            fails_q    = '0;
            retry_at_q = '0;
            expected_q.delete();
            fails      = 0;
            checked    = 0;
            due_seen   = 0;
            peak       = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = {i_res.link_up, i_res.retry_due, i_res.retry_count, i_res.next_retry_ms};
                checked++;
                if (got.retry_due) due_seen++;
                if (expected_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result with nothing pending: link_up=%0b due=%0b count=%0d next=%0d",
                                 $realtime, got.link_up, got.retry_due, got.retry_count,
                                 got.next_retry_ms);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.link_up !== want.link_up || got.retry_due !== want.retry_due ||
                        got.retry_count !== want.retry_count ||
                        got.next_retry_ms !== want.next_retry_ms) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch, expected link_up=%0b due=%0b count=%0d next=%0d",
                                     $realtime, want.link_up, want.retry_due, want.retry_count,
                                     want.next_retry_ms);
                            $display("%0t:           actual link_up=%0b due=%0b count=%0d next=%0d",
                                     $realtime, got.link_up, got.retry_due, got.retry_count,
                                     got.next_retry_ms);
                        end
                        fails++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_INITIAL: init_ms = i_cfg.data;
                    REG_MAX:     cap_ms  = i_cfg.data;
                    REG_FACTOR:  factor  = i_cfg.data[FACTOR_BITS-1:0];
                    default:     ;
                endcase
            end
            if (i_evt.valid && i_evt.ready) begin
                pred = advance_link(t_action'(i_evt.action), i_evt.succeeded, i_evt.now_ms);
                expected_q.insert(expected_q.size(), pred);
                if (int'(fails_q) > peak) peak = int'(fails_q);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_due_seen   <= due_seen;
        o_peak_count <= peak;
    end

endmodule

@@ tb/reconnect_backoff_scheduler_core_tb.sv @@
// Stimulus and verdict for the reconnect backoff scheduler core.
module reconnect_backoff_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbs_pkg::*;

    localparam int TIME_BITS   = 48;
    localparam int COUNT_BITS  = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_TAIL  = 40;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam logic [TIME_BITS-1:0]    TIME_TOP  = '1;
    localparam logic [DLY_BITS-1:0]     DLY_TOP   = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rbs_cfg_if                                                    cfg_bus ();
    rbs_evt_if #(.TIME_BITS(TIME_BITS))                           evt_bus ();
    rbs_res_if #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) res_bus ();

    int fail_count;
    int pending;
    int checked;
    int due_seen;
    int peak_count;

    int sent_cnt    = 0;
    int setting_cnt = 0;
    int cycle_cnt   = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit hold_long   = 1'b0;

    logic [DLY_BITS-1:0] cur_init = INITIAL_RST;
    logic [DLY_BITS-1:0] cur_max  = MAX_RST;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    reconnect_backoff_scheduler_core #(
        .TIME_BITS (TIME_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_evt  (evt_bus),
        .o_res  (res_bus)
    );

    rbs_backoff_tracker #(
        .TIME_BITS (TIME_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_bus),
        .i_evt       (evt_bus),
        .i_res       (res_bus),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_due_seen  (due_seen),
        .o_peak_count(peak_count)
    );

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [DLY_BITS-1:0] rand_delay();
        case ($urandom_range(0, 3))
            0:       return DLY_BITS'($urandom_range(0, 20));
            1:       return DLY_BITS'($urandom_range(21, 10000));
            2:       return DLY_BITS'($urandom);
            default: return DLY_TOP - DLY_BITS'($urandom_range(0, 3));
        endcase
    endfunction

    // time between events: land on, just before and just after likely retry times
    function automatic logic [TIME_BITS-1:0] pick_step();
        case ($urandom_range(0, 4))
            0:       return TIME_BITS'($urandom_range(0, 3));
            1:       return TIME_BITS'(cur_max) + TIME_BITS'($urandom_range(0, 4)) - TIME_BITS'(2);
            2:       return TIME_BITS'($urandom_range(0, {cur_max, 1'b0}));
            3:       return TIME_BITS'(cur_init) + TIME_BITS'($urandom_range(0, 2)) - TIME_BITS'(1);
            default: return TIME_BITS'($urandom);
        endcase
    endfunction

    task automatic send_event(input t_action act, input logic ok,
                              input logic [TIME_BITS-1:0] now);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            evt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        evt_bus.valid     <= 1'b1;
        evt_bus.action    <= act;
        evt_bus.succeeded <= ok;
        evt_bus.now_ms    <= now;
        do @(posedge i_clk); while (!evt_bus.ready);
        sent_cnt++;
    endtask

    // hold valid low until every pending result has been returned
    task automatic drain();
        evt_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DLY_BITS-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic configure(input logic [DLY_BITS-1:0] init, input logic [DLY_BITS-1:0] cap,
                             input logic [FACTOR_BITS-1:0] f);
        drain();
        write_reg(REG_INITIAL, init);
        write_reg(REG_MAX, cap);
        // upper data bits are don't-care for the factor register
        write_reg(REG_FACTOR, {(DLY_BITS-FACTOR_BITS)'($urandom), f});
        if (setting_cnt == 0) write_reg(REG_SPARE, DLY_BITS'($urandom));
        cfg_bus.valid <= 1'b0;
        cur_init = init;
        cur_max  = cap;
        setting_cnt++;
    endtask

    // loss followed by attempts, checks and re-losses; a success ends it early, and an attach may open or close it
    task automatic run_session();
        logic [TIME_BITS-1:0] t;
        int                   tries;
        case ($urandom_range(0, 2))
            0:       t = rand_time();
            1:       t = TIME_TOP - TIME_BITS'($urandom_range(0, 20000));
            default: t = TIME_BITS'($urandom_range(0, 100000));
        endcase
        if ($urandom_range(0, 3) == 0) send_event(ACT_ATTACH, 1'($urandom), t);
        send_event(ACT_LOST, 1'($urandom), t);
        tries = $urandom_range(1, 10);
        for (int k = 0; k < tries; k++) begin
            t = t + pick_step();
            case ($urandom_range(0, 9))
                0, 1: send_event(ACT_CHECK, 1'($urandom), t);
                2: begin
                    send_event(ACT_ATTEMPT, 1'b1, t);
                    if ($urandom_range(0, 1) == 1) send_event(ACT_ATTEMPT, 1'b0, t + 48'd1);
                    k = tries;
                end
                3:       send_event(ACT_LOST, 1'($urandom), t);
                default: send_event(ACT_ATTEMPT, 1'b0, t);
            endcase
        end
        if ($urandom_range(0, 4) == 0) send_event(ACT_ATTACH, 1'($urandom), t + pick_step());
    endtask

    task automatic run_mix(input int n);
        int start;
        start = sent_cnt;
        while (sent_cnt - start < n) begin
            if ($urandom_range(0, 4) == 0)
                send_event(t_action'($urandom_range(0, 3)), 1'($urandom), rand_time());
            else
                run_session();
        end
    endtask

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        res_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_long) begin
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_long = 1'b0;
            end else if ($urandom_range(0, 99) >= stall_pct) begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [TIME_BITS-1:0]   t;
        logic [FACTOR_BITS-1:0] f;
        i_rst_n           <= 1'b0;
        evt_bus.valid     <= 1'b0;
        evt_bus.action    <= ACT_CHECK;
        evt_bus.succeeded <= 1'b0;
        evt_bus.now_ms    <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= REG_INITIAL;
        cfg_bus.data      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers are in effect here
        send_event(ACT_CHECK, 1'b1, '0);
        send_event(ACT_ATTEMPT, 1'b0, 48'd5);   // attached: a failed attempt changes nothing
        send_event(ACT_LOST, 1'b1, 48'd1000);   // succeeded only matters on attempts
        send_event(ACT_CHECK, 1'b0, 48'd1099);
        send_event(ACT_CHECK, 1'b0, 48'd1100);
        for (int k = 0; k < 8; k++)
            send_event(ACT_ATTEMPT, 1'b0, 48'd1100 + TIME_BITS'(k * 1000));
        send_event(ACT_ATTACH, 1'b0, 48'd9000);
        send_event(ACT_LOST, 1'b0, TIME_TOP);   // retry time carries past the time width
        send_event(ACT_CHECK, 1'b0, TIME_TOP);
        send_event(ACT_ATTEMPT, 1'b0, TIME_TOP);
        send_event(ACT_CHECK, 1'b1, '0);
        send_event(ACT_ATTEMPT, 1'b1, 48'h5555_5555_5555);
        send_event(ACT_LOST, 1'b0, 48'hAAAA_AAAA_AAAA);
        send_event(ACT_ATTACH, 1'b1, 48'h1234);

        configure(31'd1, DLY_TOP, 8'd255);
        gap_pct   = 20;
        stall_pct = 20;
        run_mix(120);

        // initial above a zero cap; the receiver holds off while events keep coming
        configure(DLY_TOP, '0, 8'd2);
        gap_pct   = 0;
        stall_pct = 0;
        hold_long = 1'b1;
        run_mix(120);

        configure('0, 31'd1000, 8'd3);
        gap_pct   = 30;
        stall_pct = 30;
        run_mix(120);

        configure(31'd7, 31'd100000, 8'd1);
        gap_pct   = 10;
        stall_pct = 40;
        run_mix(120);

        configure(31'd50, 31'd3000, 8'd0);
        gap_pct   = 25;
        stall_pct = 10;
        run_mix(120);

        configure(DLY_TOP, DLY_TOP, 8'd255);
        gap_pct   = 15;
        stall_pct = 15;
        run_mix(100);

        // drive the retry count into saturation
        configure(31'd1, DLY_TOP, 8'd2);
        gap_pct   = 10;
        stall_pct = 10;
        t = TIME_BITS'(1000);
        send_event(ACT_LOST, 1'b0, t);
        for (int k = 0; k < 270; k++) begin
            t = t + TIME_BITS'($urandom_range(0, 32'h8000_0000));
            send_event(ACT_ATTEMPT, 1'b0, t);
        end
        send_event(ACT_CHECK, 1'b0, t);
        send_event(ACT_ATTEMPT, 1'b1, t);

        for (int n = 0; n < 4; n++) begin
            case ($urandom_range(0, 2))
                0:       f = FACTOR_BITS'($urandom_range(0, 2));
                1:       f = FACTOR_BITS'($urandom_range(3, 8));
                default: f = FACTOR_BITS'($urandom);
            endcase
            configure(rand_delay(), rand_delay(), f);
            gap_pct   = $urandom_range(0, 35);
            stall_pct = $urandom_range(0, 35);
            run_mix(120);
        end

        // closing stretch runs back to back on both sides
        configure(rand_delay(), rand_delay(), FACTOR_BITS'($urandom_range(0, 4)));
        gap_pct   = 0;
        stall_pct = 0;
        run_mix(100);

        drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("summary: %0d events under %0d register settings, %0d results compared",
                 sent_cnt, setting_cnt + 1, checked);
        $display("summary: %0d results with a retry due, highest retry count %0d",
                 due_seen, peak_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rbs_pkg.sv
hdl/rbs_ifs.sv
hdl/rbs_cfg_regs.sv
hdl/rbs_backoff.sv
hdl/reconnect_backoff_scheduler_core.sv
tb/rbs_backoff_tracker.sv
tb/reconnect_backoff_scheduler_core_tb.sv
